>>> rtl/trimmed_nine_point_curve_core_assert.svh
// ----------------------------------------------------------------------------
// trimmed_nine_point_curve_core_assert.svh
// Assertion macros for the trimmed nine-point curve core. Empty bodies when
// the design is built for synthesis.
// ----------------------------------------------------------------------------
`ifndef TRIMMED_NINE_POINT_CURVE_CORE_ASSERT_SVH
`define TRIMMED_NINE_POINT_CURVE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define TNPC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tnpc assertion failed");

// Check that a condition never holds outside reset.
`define TNPC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `TNPC_ASSERT(lbl, clk, rst_n, !(cond))

`else

`define TNPC_ASSERT(lbl, clk, rst_n, prop)
`define TNPC_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> rtl/tnpc_pkg.sv
// ----------------------------------------------------------------------------
// tnpc_pkg
// Shared types and constants of the trimmed nine-point curve core.
// ----------------------------------------------------------------------------
package tnpc_pkg;

  // Field widths
  localparam int unsigned STICK_W = 10;
  localparam int unsigned CURVE_W = 10;
  localparam int unsigned PTS_W   = 30;
  localparam int unsigned TRIM_W  = 8;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned REM_W   = 6;
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Curve geometry
  localparam logic [IDX_W-1:0] TOP_POINT = 4'd8;
  localparam logic [IDX_W-1:0] MID_POINT = 4'd4;

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PTS_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PTS_MIDDLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PTS_LAST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TRIM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_TRIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TRIM  = 3'd5;

  // Reset values: linear curve -256..256 in steps of 64, no trim
  localparam logic [PTS_W-1:0] PTS_FIRST_RST  = 30'd940376832;
  localparam logic [PTS_W-1:0] PTS_MIDDLE_RST = 30'd67109824;
  localparam logic [PTS_W-1:0] PTS_LAST_RST   = 30'd268632192;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [REM_W-1:0] rem;
  } item_t;

  typedef struct packed {
    logic [PTS_W-1:0]         pts_first;
    logic [PTS_W-1:0]         pts_middle;
    logic [PTS_W-1:0]         pts_last;
    logic signed [TRIM_W-1:0] low_trim;
    logic signed [TRIM_W-1:0] center_trim;
    logic signed [TRIM_W-1:0] high_trim;
  } cfg_t;

endpackage

>>> rtl/tnpc_front.sv
// ----------------------------------------------------------------------------
// tnpc_front
// Clamp the stick sample and split it into segment index and remainder.
// ----------------------------------------------------------------------------
module tnpc_front (
  input  logic                           in_tvalid,
  input  logic [tnpc_pkg::DATA_W-1:0]    in_tdata,
  input  logic                           q_full,
  output logic                           in_tready,
  output logic                           q_push,
  output tnpc_pkg::item_t                q_item
);

  logic signed [tnpc_pkg::STICK_W-1:0] stick;
  logic signed [tnpc_pkg::STICK_W-1:0] clamped;
  logic        [tnpc_pkg::STICK_W:0]   offset;

  assign stick = $signed(in_tdata[tnpc_pkg::STICK_W-1:0]);

  always_comb begin
    if (stick < -10'sd256) begin
      clamped = -10'sd256;
    end else if (stick > 10'sd256) begin
      clamped = 10'sd256;
    end else begin
      clamped = stick;
    end
  end

  // Offset into 0..512
  assign offset = 11'($signed(11'(clamped)) + 11'sd256);

  assign q_item.idx = offset[tnpc_pkg::REM_W +: tnpc_pkg::IDX_W];
  assign q_item.rem = offset[tnpc_pkg::REM_W-1:0];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule

>>> rtl/tnpc_fifo.sv
// ----------------------------------------------------------------------------
// tnpc_fifo
// Short item queue between the front and back parts.
// ----------------------------------------------------------------------------
`include "trimmed_nine_point_curve_core_assert.svh"

module tnpc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tnpc_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output tnpc_pkg::item_t head_item
);

  tnpc_pkg::item_t                    mem_r [tnpc_pkg::QDEPTH];
  logic [tnpc_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [tnpc_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [tnpc_pkg::QCNT_W-1:0]        count_r, count_nxt;

  localparam logic [tnpc_pkg::QPTR_W-1:0] PTR_LAST = tnpc_pkg::QPTR_W'(tnpc_pkg::QDEPTH - 1);
  localparam logic [tnpc_pkg::QCNT_W-1:0] CNT_FULL = tnpc_pkg::QCNT_W'(tnpc_pkg::QDEPTH);

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `TNPC_ASSERT_NEVER(a_cnt_bound, clk, rst_n, count_r > CNT_FULL)
  `TNPC_ASSERT(a_cnt_up, clk, rst_n, (rst_n && push && !pop) |=> (count_r == $past(count_r) + 1'b1))
  `TNPC_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && (count_r == '0))

endmodule

>>> rtl/tnpc_back.sv
// ----------------------------------------------------------------------------
// tnpc_back
// Trim the two neighboring points, then blend them by the remainder.
// ----------------------------------------------------------------------------
module tnpc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tnpc_pkg::cfg_t              cfg,
  input  logic                        q_not_empty,
  input  tnpc_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        out_vld,
  output logic [tnpc_pkg::CURVE_W-1:0] out_curve,
  input  logic                        out_rdy
);

  // Signed division by four, truncating toward zero
  function automatic logic signed [10:0] div4tz(input logic signed [10:0] x);
    logic signed [10:0] b;
    b = x + (x[10] ? 11'sd3 : 11'sd0);
    return b >>> 2;
  endfunction

  function automatic logic signed [9:0] trim_pt(input logic [3:0] i, input tnpc_pkg::cfg_t c);
    logic signed [9:0]  raw;
    logic signed [7:0]  side;
    logic        [2:0]  w_side;
    logic        [2:0]  w_ce;
    logic signed [10:0] t_side;
    logic signed [10:0] t_ce;
    logic signed [11:0] p;
    logic signed [9:0]  res;
    case (i)
      4'd0:    raw = $signed(c.pts_first[9:0]);
      4'd1:    raw = $signed(c.pts_first[19:10]);
      4'd2:    raw = $signed(c.pts_first[29:20]);
      4'd3:    raw = $signed(c.pts_middle[9:0]);
      4'd4:    raw = $signed(c.pts_middle[19:10]);
      4'd5:    raw = $signed(c.pts_middle[29:20]);
      4'd6:    raw = $signed(c.pts_last[9:0]);
      4'd7:    raw = $signed(c.pts_last[19:10]);
      default: raw = $signed(c.pts_last[29:20]);
    endcase
    if (i < tnpc_pkg::MID_POINT) begin
      side   = c.low_trim;
      w_side = 3'(tnpc_pkg::MID_POINT - i);
      w_ce   = 3'(i);
    end else begin
      side   = c.high_trim;
      w_side = 3'(i - tnpc_pkg::MID_POINT);
      w_ce   = 3'(tnpc_pkg::TOP_POINT - i);
    end
    t_side = side * $signed({1'b0, w_side});
    t_ce   = c.center_trim * $signed({1'b0, w_ce});
    p = 12'(raw) + 12'(div4tz(t_side)) + 12'(div4tz(t_ce));
    if (p < -12'sd256) begin
      res = -10'sd256;
    end else if (p > 12'sd256) begin
      res = 10'sd256;
    end else begin
      res = p[9:0];
    end
    return res;
  endfunction

  logic                             s1_vld_r;
  logic signed [9:0]                s1_a_r, s1_a_nxt;
  logic signed [9:0]                s1_b_r, s1_b_nxt;
  logic [tnpc_pkg::REM_W-1:0]       s1_rem_r;
  logic [tnpc_pkg::IDX_W-1:0]       idx_b;
  logic                             out_vld_r;
  logic [tnpc_pkg::CURVE_W-1:0]     curve_r, curve_nxt;
  logic                             out_en, s1_en;
  logic [tnpc_pkg::REM_W:0]         w_a;
  logic signed [17:0]               prod_a, prod_b, sum;

  assign out_en = !out_vld_r || out_rdy;
  assign s1_en  = !s1_vld_r || out_en;
  assign q_pop  = s1_en && q_not_empty;

  // Top segment: the upper neighbor is point eight again
  assign idx_b    = (q_item.idx >= tnpc_pkg::TOP_POINT) ? tnpc_pkg::TOP_POINT : q_item.idx + 4'd1;
  assign s1_a_nxt = trim_pt(q_item.idx, cfg);
  assign s1_b_nxt = trim_pt(idx_b, cfg);

  assign w_a       = 7'd64 - {1'b0, s1_rem_r};
  assign prod_a    = s1_a_r * $signed({1'b0, w_a});
  assign prod_b    = s1_b_r * $signed({2'b00, s1_rem_r});
  assign sum       = prod_a + prod_b;
  assign curve_nxt = sum[15:6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_vld_r <= q_not_empty;
      end
      if (out_en) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_a_r   <= s1_a_nxt;
      s1_b_r   <= s1_b_nxt;
      s1_rem_r <= q_item.rem;
    end
    if (out_en && s1_vld_r) begin
      curve_r <= curve_nxt;
    end
  end

  assign out_vld   = out_vld_r;
  assign out_curve = curve_r;

endmodule

>>> rtl/trimmed_nine_point_curve_core.sv
// Path: an accepted item is stored in the queue, then in stage one, then in the
//   output register. Throughput: one item per cycle unless the output stalls; the
//   front takes one while the two-entry queue has room, the back drains one per cycle.
// Reset (rst_n low, synchronous): queue and pipeline emptied, curve points
//   back to the linear curve, all trims zero.
// ----------------------------------------------------------------------------
// trimmed_nine_point_curve_core
// Nine-point piecewise-linear curve with low, center and high trims.
// ----------------------------------------------------------------------------
module trimmed_nine_point_curve_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tnpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tnpc_pkg::PTS_W-1:0]        cfg_data,
  // Sample input
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tnpc_pkg::DATA_W-1:0]       in_tdata,   // [9:0] stick_value, [15:10] zero
  // Curve output
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tnpc_pkg::DATA_W-1:0]       out_tdata   // [9:0] curve_value, [15:10] zero
);

  // Configuration registers: always ready, unknown indexes are dropped
  logic [tnpc_pkg::PTS_W-1:0]         pts_first_r, pts_middle_r, pts_last_r;
  logic signed [tnpc_pkg::TRIM_W-1:0] low_trim_r, center_trim_r, high_trim_r;
  tnpc_pkg::cfg_t                     cfg;
  logic                               cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_first_r   <= tnpc_pkg::PTS_FIRST_RST;
      pts_middle_r  <= tnpc_pkg::PTS_MIDDLE_RST;
      pts_last_r    <= tnpc_pkg::PTS_LAST_RST;
      low_trim_r    <= '0;
      center_trim_r <= '0;
      high_trim_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        tnpc_pkg::CFG_PTS_FIRST:   pts_first_r   <= cfg_data;
        tnpc_pkg::CFG_PTS_MIDDLE:  pts_middle_r  <= cfg_data;
        tnpc_pkg::CFG_PTS_LAST:    pts_last_r    <= cfg_data;
        tnpc_pkg::CFG_LOW_TRIM:    low_trim_r    <= $signed(cfg_data[tnpc_pkg::TRIM_W-1:0]);
        tnpc_pkg::CFG_CENTER_TRIM: center_trim_r <= $signed(cfg_data[tnpc_pkg::TRIM_W-1:0]);
        tnpc_pkg::CFG_HIGH_TRIM:   high_trim_r   <= $signed(cfg_data[tnpc_pkg::TRIM_W-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg.pts_first   = pts_first_r;
  assign cfg.pts_middle  = pts_middle_r;
  assign cfg.pts_last    = pts_last_r;
  assign cfg.low_trim    = low_trim_r;
  assign cfg.center_trim = center_trim_r;
  assign cfg.high_trim   = high_trim_r;

  // Front: clamp and split each sample into index and remainder
  logic            q_push, q_pop, q_full, q_not_empty;
  tnpc_pkg::item_t push_item, head_item;

  tnpc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .in_tready (in_tready),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  // Queue: lets the front keep accepting while the output stalls
  tnpc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  // Back: trim both neighbors in one stage, blend them into the output register
  logic [tnpc_pkg::CURVE_W-1:0] curve;

  tnpc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_item      (head_item),
    .q_pop       (q_pop),
    .out_vld     (out_tvalid),
    .out_curve   (curve),
    .out_rdy     (out_tready)
  );

  assign out_tdata = {{(tnpc_pkg::DATA_W - tnpc_pkg::CURVE_W){1'b0}}, curve};

endmodule
